[sv/mlfq_pkg.sv]
package mlfq_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRD,
    ST_DCALC,
    ST_DDONE,
    ST_BRD,
    ST_BMOVE,
    ST_OUT
  } mlfq_state_e;

  localparam logic FUNC_ARRIVE   = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;

  localparam logic [1:0] CFG_Q0    = 2'd0;
  localparam logic [1:0] CFG_Q1    = 2'd1;
  localparam logic [1:0] CFG_Q2    = 2'd2;
  localparam logic [1:0] CFG_BOOST = 2'd3;

endpackage

[sv/mlfq_slice_scheduler_core.sv]
// Three-level feedback queue scheduler. Raise start with func_i=0 to add a
// task to level 0, or func_i=1 to run one slice. Every request returns exactly
// one result, marked by a one-cycle done_o strobe that cannot be stalled.
// busy is high while a request is in work. An arrival passes through the
// output step only; a dispatch passes through ring read, task read, update,
// boost check and output; a dispatch with nothing ready passes through boost
// check and output. A dispatch that triggers a priority boost adds a boost
// pass that moves every queued entry from levels 2 and 1 into level 0, one
// at a time, since every move is a read then a write of the single ring
// memory. The next request can be accepted at the edge that ends the done_o
// cycle. Task and ring state sit in synchronous RAMs and need no clearing
// after reset. Configuration is accepted only while busy is low.
module mlfq_slice_scheduler_core #(
  parameter int MAX_TASKS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        func_i,
  input  logic [5:0]  proc_id_i,
  input  logic [15:0] burst_time_i,
  input  logic [31:0] arrival_time_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic [5:0]  ran_id_o,
  output logic [1:0]  ran_level_o,
  output logic [15:0] slice_len_o,
  output logic [31:0] time_after_o,
  output logic        task_done_o,
  output logic [31:0] turnaround_o,
  output logic        went_idle_o,
  output logic        boosted_o,
  output logic        arrival_dropped_o
);
  import mlfq_pkg::*;

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = AW + 1;

  // Task store and one ring memory (address is level * MAX_TASKS + position).
  logic [15:0]   rem_mem [MAX_TASKS];
  logic [31:0]   arr_mem [MAX_TASKS];
  logic [AW-1:0] ring_mem [3*MAX_TASKS];

  logic [15:0] q0_q, q1_q, q2_q, bi_q;
  logic [AW-1:0] head_q [3];
  logic [CW-1:0] cnt_q [3];
  logic [31:0] time_q;
  logic [16:0] since_q;
  mlfq_state_e state_q, state_d;

  // latched request and result
  logic          func_q;
  logic [AW-1:0] slot_q;
  logic [1:0]    lvl_q;
  logic [15:0]   slice_q;
  logic [31:0]   tat_q;
  logic          done_q, idle_q, boost_q, drop_q;

  // memory ports
  logic           ring_we;
  logic [AW+1:0]  ring_waddr, ring_raddr;
  logic [AW-1:0]  ring_wdata, ring_rd_q;
  logic           task_we;
  logic [AW-1:0]  task_waddr, task_raddr;
  logic [15:0]    task_wrem, rem_rd_q;
  logic [31:0]    task_warr, arr_rd_q;
  logic           arr_we;

  function automatic logic [AW+1:0] raddr(input logic [1:0] l, input logic [AW-1:0] i);
    raddr = (AW+2)'(l) * (AW+2)'(MAX_TASKS) + (AW+2)'(i);
  endfunction

  // ring position h + n, wrapped at MAX_TASKS (n never exceeds MAX_TASKS)
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] h,
                                             input logic [CW-1:0] n);
    logic [CW-1:0] s;
    s = CW'(h) + n;
    ring_pos = (s >= CW'(MAX_TASKS)) ? AW'(s - CW'(MAX_TASKS)) : AW'(s);
  endfunction

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    ring_rd_q <= ring_mem[ring_raddr];
    if (task_we) rem_mem[task_waddr] <= task_wrem;
    if (arr_we) arr_mem[task_waddr] <= task_warr;
    rem_rd_q <= rem_mem[task_raddr];
    arr_rd_q <= arr_mem[task_raddr];
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy;

  // level selection and tail positions
  logic [1:0]    sel_lvl;
  logic          none_ready;
  logic [AW-1:0] tail0, tailn;
  logic [15:0]   quant;
  logic [15:0]   slice_c;
  logic [15:0]   rem_new;
  logic [16:0]   since_sum;
  logic [1:0]    push_lvl;

  always_comb begin
    none_ready = 1'b0;
    sel_lvl = 2'd0;
    if (cnt_q[0] != '0) sel_lvl = 2'd0;
    else if (cnt_q[1] != '0) sel_lvl = 2'd1;
    else if (cnt_q[2] != '0) sel_lvl = 2'd2;
    else none_ready = 1'b1;
    tail0 = ring_pos(head_q[0], cnt_q[0]);
    push_lvl = (lvl_q == 2'd2) ? 2'd2 : lvl_q + 2'd1;
    tailn = ring_pos(head_q[push_lvl], cnt_q[push_lvl]);
    case (lvl_q)
      2'd0:    quant = q0_q;
      2'd1:    quant = q1_q;
      default: quant = q2_q;
    endcase
    slice_c   = (rem_rd_q < quant) ? rem_rd_q : quant;
    rem_new   = rem_rd_q - slice_c;
    since_sum = since_q + 17'(slice_q);
  end

  always_comb begin
    state_d    = state_q;
    ring_we    = 1'b0;
    ring_waddr = raddr(2'd0, tail0);
    ring_wdata = slot_q;
    ring_raddr = raddr(sel_lvl, head_q[sel_lvl]);
    task_we    = 1'b0;
    arr_we     = 1'b0;
    task_waddr = slot_q;
    task_raddr = ring_rd_q;
    task_wrem  = burst_time_i;
    task_warr  = arrival_time_i;
    unique case (state_q)
      ST_IDLE: begin
        task_waddr = AW'(proc_id_i);
        if (start) begin
          if (func_i == FUNC_ARRIVE) begin
            state_d = ST_OUT;
            if (32'(proc_id_i) < 32'(MAX_TASKS) && cnt_q[0] != CW'(MAX_TASKS)) begin
              task_we = 1'b1;
              arr_we  = 1'b1;
              ring_we = 1'b1;
              ring_wdata = AW'(proc_id_i);
            end
          end else begin
            state_d = none_ready ? ST_DDONE : ST_DRD;
          end
        end
      end
      ST_DRD:   state_d = ST_DCALC;
      ST_DCALC: begin
        task_we   = 1'b1;
        task_waddr = slot_q;
        task_wrem = rem_new;
        // a push into a full level is lost
        if (rem_new != '0 && cnt_q[push_lvl] != CW'(MAX_TASKS)) begin
          ring_we    = 1'b1;
          ring_waddr = raddr(push_lvl, tailn);
        end
        state_d = ST_DDONE;
      end
      ST_DDONE: state_d = (since_sum >= 17'(bi_q)) ? ST_BRD : ST_OUT;
      ST_BRD: begin
        if (cnt_q[2] != '0) begin
          ring_raddr = raddr(2'd2, head_q[2]);
          state_d = ST_BMOVE;
        end else if (cnt_q[1] != '0) begin
          ring_raddr = raddr(2'd1, head_q[1]);
          state_d = ST_BMOVE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_BMOVE: begin
        ring_wdata = ring_rd_q;
        ring_we    = (cnt_q[0] != CW'(MAX_TASKS));
        state_d    = ST_BRD;
      end
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      q0_q <= 16'd2; q1_q <= 16'd4; q2_q <= 16'd6; bi_q <= 16'd50;
      for (int i = 0; i < 3; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      time_q <= '0; since_q <= '0;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == ST_OUT);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_Q0:    q0_q <= cfg_data_i;
          CFG_Q1:    q1_q <= cfg_data_i;
          CFG_Q2:    q2_q <= cfg_data_i;
          CFG_BOOST: bi_q <= cfg_data_i;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start && func_i == FUNC_ARRIVE && ring_we) cnt_q[0] <= cnt_q[0] + 1'b1;
          if (start && func_i == FUNC_DISPATCH && !none_ready) begin
            head_q[sel_lvl] <= ring_pos(head_q[sel_lvl], CW'(1));
            cnt_q[sel_lvl]  <= cnt_q[sel_lvl] - 1'b1;
          end
          if (start && func_i == FUNC_DISPATCH && none_ready) begin
            time_q <= time_q + 32'd1;
            since_q <= since_q + 17'd1;
          end
        end
        ST_DRD: ;
        ST_DCALC: begin
          time_q <= time_q + 32'(slice_c);
          if (rem_new != '0 && cnt_q[push_lvl] != CW'(MAX_TASKS))
            cnt_q[push_lvl] <= cnt_q[push_lvl] + 1'b1;
        end
        ST_DDONE: begin
          if (since_sum >= 17'(bi_q)) since_q <= '0;
          else since_q <= since_sum;
        end
        ST_BRD: begin
          if (cnt_q[2] != '0) begin
            head_q[2] <= ring_pos(head_q[2], CW'(1));
            cnt_q[2]  <= cnt_q[2] - 1'b1;
          end else if (cnt_q[1] != '0) begin
            head_q[1] <= ring_pos(head_q[1], CW'(1));
            cnt_q[1]  <= cnt_q[1] - 1'b1;
          end
        end
        ST_BMOVE: if (ring_we) cnt_q[0] <= cnt_q[0] + 1'b1;
        default: ;
      endcase
    end
  end

  // request/result payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (start) begin
        func_q  <= func_i;
        slot_q  <= AW'(proc_id_i);
        lvl_q   <= sel_lvl;
        slice_q <= '0;
        tat_q   <= '0;
        done_q  <= 1'b0;
        boost_q <= 1'b0;
        idle_q  <= (func_i == FUNC_DISPATCH) && none_ready;
        drop_q  <= (func_i == FUNC_ARRIVE) && !ring_we;
      end
      ST_DRD: slot_q <= ring_rd_q;
      ST_DCALC: begin
        slice_q <= slice_c;
        done_q  <= (rem_new == '0);
        tat_q   <= (rem_new == '0) ? time_q + 32'(slice_c) - arr_rd_q : '0;
      end
      ST_DDONE: boost_q <= (since_sum >= 17'(bi_q));
      default: ;
    endcase
  end

  // slice only counts toward since_boost once; idle dispatch leaves slice 0
  assign ran_id_o          = (func_q == FUNC_DISPATCH && !idle_q) ? 6'(slot_q) : '0;
  assign ran_level_o       = (func_q == FUNC_DISPATCH && !idle_q) ? lvl_q : '0;
  assign slice_len_o       = slice_q;
  assign time_after_o      = time_q;
  assign task_done_o       = done_q;
  assign turnaround_o      = tat_q;
  assign went_idle_o       = idle_q;
  assign boosted_o         = boost_q;
  assign arrival_dropped_o = drop_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CW'(MAX_TASKS)) else $error("level 0 count overflow");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
endmodule
